// ----- rtl/core/dvft_pkg.sv -----
// shared constants and payload types for the distinct value frequency table
// no dependencies; every other file of the block refers to this package

package dvft_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    // payload widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // back end state codes
    localparam logic ST_ABSORB = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    typedef struct packed {
        t_value value;
        logic   set_end;
    } t_item;

    typedef struct packed {
        t_value distinct_value;
        t_count occurrences;
        logic   table_overflowed;
        logic   last_entry;
    } t_result;

endpackage

// ----- rtl/core/dvft_in_if.sv -----
// input item channel: valid/ready handshake with value and set end marker
// depends on dvft_pkg for the payload types

interface dvft_in_if;
    logic              valid;
    logic              ready;
    dvft_pkg::t_value  value;
    logic              set_end;

    modport source (output valid, output value, output set_end, input ready);
    modport sink   (input valid, input value, input set_end, output ready);
endinterface

// ----- rtl/core/dvft_out_if.sv -----
// result channel: valid/ready handshake carrying one table entry per beat
// depends on dvft_pkg for the payload types

interface dvft_out_if;
    logic              valid;
    logic              ready;
    dvft_pkg::t_value  distinct_value;
    dvft_pkg::t_count  occurrences;
    logic              table_overflowed;
    logic              last_entry;

    modport source (output valid, output distinct_value, output occurrences,
                    output table_overflowed, output last_entry, input ready);
    modport sink   (input valid, input distinct_value, input occurrences,
                    input table_overflowed, input last_entry, output ready);
endinterface

// ----- rtl/core/dvft_queue.sv -----
// front end: short item queue that takes input beats and decouples the table
// depends on dvft_pkg and dvft_in_if

module dvft_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dvft_in_if.sink      i_item,
    dvft_in_if.source    o_item
);

    dvft_pkg::t_item             r_slot [dvft_pkg::QUEUE_DEPTH];
    logic [dvft_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [dvft_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [dvft_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        push, pop;

    // handshake view
    assign i_item.ready = (r_count != dvft_pkg::QCNT_W'(dvft_pkg::QUEUE_DEPTH));
    assign o_item.valid = (r_count != '0);
    assign o_item.value   = r_slot[r_rd_ptr].value;
    assign o_item.set_end = r_slot[r_rd_ptr].set_end;

    assign push = i_item.valid && i_item.ready;
    assign pop  = o_item.valid && o_item.ready;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            if (r_wr_ptr == dvft_pkg::QPTR_W'(dvft_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + dvft_pkg::QPTR_W'(1);
            end
        end
        if (pop) begin
            if (r_rd_ptr == dvft_pkg::QPTR_W'(dvft_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + dvft_pkg::QPTR_W'(1);
            end
        end
        if (push && !pop) begin
            n_count = r_count + dvft_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - dvft_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= '{value: i_item.value, set_end: i_item.set_end};
        end
    end

endmodule

// ----- rtl/core/dvft_table.sv -----
// back end: distinct value table with parallel match, counting and emission
// depends on dvft_pkg, dvft_in_if and dvft_out_if

module dvft_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dvft_in_if.sink      i_item,
    dvft_out_if.source   o_result
);

    dvft_pkg::t_value             r_val [dvft_pkg::TABLE_DEPTH];
    dvft_pkg::t_count             r_cnt [dvft_pkg::TABLE_DEPTH];
    logic                         r_state, n_state;
    logic [dvft_pkg::USED_W-1:0]  r_used, n_used;
    logic                         r_ovf, n_ovf;
    logic [dvft_pkg::IDX_W-1:0]   r_emit_idx, n_emit_idx;
    dvft_pkg::t_result            r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic [dvft_pkg::TABLE_DEPTH-1:0] hit;
    logic [dvft_pkg::IDX_W-1:0]       hit_idx;
    logic                             any_hit;
    logic                             absorb;
    logic                             full;
    logic                             append;
    logic                             bump;
    logic                             slot_free;
    logic                             emit_last;
    logic [dvft_pkg::IDX_W-1:0]       wr_idx;

    assign i_item.ready = (r_state == dvft_pkg::ST_ABSORB);
    assign absorb       = i_item.valid && i_item.ready;
    assign full         = (r_used == dvft_pkg::USED_W'(dvft_pkg::TABLE_DEPTH));
    assign slot_free    = !r_out_valid || o_result.ready;
    assign emit_last    = ((dvft_pkg::USED_W'(r_emit_idx) + dvft_pkg::USED_W'(1)) == r_used);
    assign wr_idx       = r_used[dvft_pkg::IDX_W-1:0];

    // parallel compare against the live entries; stored values are distinct
    always_comb begin
        hit     = '0;
        hit_idx = '0;
        for (int i = 0; i < dvft_pkg::TABLE_DEPTH; i++) begin
            hit[i] = (dvft_pkg::USED_W'(i) < r_used) && (r_val[i] == i_item.value);
            if (hit[i]) begin
                hit_idx = hit_idx | dvft_pkg::IDX_W'(i);
            end
        end
        any_hit = |hit;
    end

    assign bump   = absorb && any_hit;
    assign append = absorb && !any_hit && !full;

    // control: absorb beats, then walk the table on set end
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_ovf       = r_ovf;
        n_emit_idx  = r_emit_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            dvft_pkg::ST_ABSORB: begin
                if (absorb) begin
                    if (append) begin
                        n_used = r_used + dvft_pkg::USED_W'(1);
                    end else if (!any_hit) begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.set_end) begin
                        n_state    = dvft_pkg::ST_EMIT;
                        n_emit_idx = '0;
                    end
                end
            end
            dvft_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{distinct_value:   r_val[r_emit_idx],
                              occurrences:      r_cnt[r_emit_idx],
                              table_overflowed: r_ovf,
                              last_entry:       emit_last};
                    n_emit_idx = r_emit_idx + dvft_pkg::IDX_W'(1);
                    if (emit_last) begin
                        n_used  = '0;
                        n_ovf   = 1'b0;
                        n_state = dvft_pkg::ST_ABSORB;
                    end
                end
            end
            default: begin
                n_state = dvft_pkg::ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dvft_pkg::ST_ABSORB;
            r_used      <= '0;
            r_ovf       <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_ovf       <= n_ovf;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // table writes: append a new value or bump a saturating count
    always_ff @(posedge i_clk) begin
        if (append) begin
            r_val[wr_idx] <= i_item.value;
            r_cnt[wr_idx] <= dvft_pkg::COUNT_W'(1);
        end else if (bump && (r_cnt[hit_idx] != dvft_pkg::COUNT_MAX)) begin
            r_cnt[hit_idx] <= r_cnt[hit_idx] + dvft_pkg::COUNT_W'(1);
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.distinct_value   = r_out.distinct_value;
    assign o_result.occurrences      = r_out.occurrences;
    assign o_result.table_overflowed = r_out.table_overflowed;
    assign o_result.last_entry       = r_out.last_entry;

endmodule

// ----- rtl/core/distinct_value_frequency_table.sv -----
// Counts how often each distinct signed 32-bit value occurs in a set. Values
// arrive one per beat and the last one of a set carries set_end. While a set
// streams in, the block absorbs one beat per clock: every beat is compared in
// parallel against all stored entries, and a two-beat queue in front keeps the
// input flowing. After the set_end beat, the table is read out one entry per
// cycle while the output is not stalled, in order of first appearance, so the
// table takes no new beats until all of its entries have been read out;
// the final entry carries last_entry and the table is then empty again.
// Counts saturate at 65535. Up to 32 distinct values are kept; further new
// values are dropped and table_overflowed is set on every entry of that set.
//
// top level: front queue feeding the table back end
// depends on dvft_pkg, dvft_in_if, dvft_out_if, dvft_queue and dvft_table

module distinct_value_frequency_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dvft_in_if.sink      i_item,
    dvft_out_if.source   o_result
);

    // queued beats between front and back
    dvft_in_if u_queued ();

    dvft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_item  (u_queued.source)
    );

    dvft_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (u_queued.sink),
        .o_result (o_result)
    );

endmodule
